>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent check forms used by the filter top level.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CHK_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> rtl/mciir_pkg.sv
// ----------------------------------------------------------------------------
// mciir_pkg
// Types, widths and coefficient tables of the multichannel sixth-order filter.
// ----------------------------------------------------------------------------
package mciir_pkg;

  localparam int TAPS     = 6;
  localparam int NUM_COEF = 13;
  localparam int A_BASE   = 7;    // first feedback coefficient in a set
  localparam int COEF_W   = 64;
  localparam int SAMPLE_W = 24;
  localparam int HIST_W   = 48;
  localparam int CHUNK_W  = 25;
  localparam int ACC_W    = 116;
  localparam int K_W      = 4;
  localparam int FSEL_W   = 2;
  localparam int NUM_SETS = 4;

  localparam logic [FSEL_W-1:0] FSEL_RESET = 2'd1;

  typedef struct packed {
    logic rd;
    logic wr_x;
    logic wr_y;
    logic mark;
  } hist_ctl_t;

  typedef struct packed {
    logic                      launch;
    logic                      first;
    logic                      shift_up;   // chunk has integer weight: a sample or the upper half of a Q24.24 word
    logic [COEF_W-1:0]         coef;
    logic signed [CHUNK_W-1:0] chunk;
  } mac_op_t;

  // Decimal mantissa / 10^dec to Q8.56, round half away from zero
  function automatic logic [COEF_W-1:0] q56_of(input longint mant, input int dec);
    logic [127:0]      v;
    logic [COEF_W-1:0] mag;
    logic [COEF_W-1:0] q;
    int                i;
    mag = (mant < 0) ? 64'(-mant) : 64'(mant);
    v = {64'd0, mag} << 57;
    for (i = 0; i < 26; i++) begin
      if (i < dec) v = v / 128'd10;
    end
    q = (v[63:0] + 64'd1) >> 1;
    return (mant < 0) ? -q : q;
  endfunction

  // Per set: b0..b6, then the feedback terms already negated (-a1..-a6)
  localparam logic [COEF_W-1:0] COEF_TBL [NUM_SETS][NUM_COEF] = '{
    '{ q56_of(64'sd97370660619115, 15), q56_of(64'sd0, 0),
       q56_of(-64'sd292111981857345, 15), q56_of(64'sd0, 0),
       q56_of(64'sd292111981857345, 15), q56_of(64'sd0, 0),
       q56_of(-64'sd97370660619115, 15),
       q56_of(64'sd3572491927808352, 15), q56_of(-64'sd5150069318347765, 15),
       q56_of(64'sd4062855454893695, 15), q56_of(-64'sd202312119907885, 14),
       q56_of(64'sd59543104015813, 14), q56_of(-64'sd57588101186343, 15) },
    '{ q56_of(64'sd17191109807913, 15), q56_of(64'sd0, 0),
       q56_of(-64'sd51573329423738, 15), q56_of(64'sd0, 0),
       q56_of(64'sd51573329423738, 15), q56_of(64'sd0, 0),
       q56_of(-64'sd17191109807913, 15),
       q56_of(64'sd4764804432822384, 15), q56_of(-64'sd9497046782060337, 15),
       q56_of(64'sd10184176520515694, 15), q56_of(-64'sd6222038193995396, 15),
       q56_of(64'sd2055665755921440, 15), q56_of(-64'sd285562022593089, 15) },
    '{ q56_of(64'sd953048321967569, 17), q56_of(64'sd0, 0),
       q56_of(-64'sd285914496590271, 16), q56_of(64'sd0, 0),
       q56_of(64'sd285914496590271, 16), q56_of(64'sd0, 0),
       q56_of(-64'sd953048321967569, 17),
       q56_of(64'sd50121175348964, 13), q56_of(-64'sd105059498143747, 13),
       q56_of(64'sd118143938042749, 13), q56_of(-64'sd753076182707842, 14),
       q56_of(64'sd258152803157766, 14), q56_of(-64'sd37132789227498, 14) },
    '{ q56_of(64'sd6005792484924, 26), q56_of(64'sd36034754909545, 26),
       q56_of(64'sd90086887273863, 26), q56_of(64'sd120115849698485, 26),
       q56_of(64'sd90086887273863, 26), q56_of(64'sd36034754909545, 26),
       q56_of(64'sd6005792484924, 26),
       q56_of(64'sd5951447334984480, 15), q56_of(-64'sd14758413952404259, 15),
       q56_of(64'sd19519164387201208, 15), q56_of(-64'sd14521482981667386, 15),
       q56_of(64'sd5761891935232461, 15), q56_of(-64'sd952606723350350, 15) }
  };

endpackage

>>> rtl/mciir_if.sv
// ----------------------------------------------------------------------------
// mciir_in_if / mciir_out_if
// Valid/ready channels carrying samples in and filtered results out.
// ----------------------------------------------------------------------------
interface mciir_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         channel;
  logic signed [23:0] sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink (input valid, input channel, input sample, output ready);
endinterface

interface mciir_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         out_channel;
  logic signed [23:0] filtered;

  modport source (output valid, output out_channel, output filtered, input ready);
  modport sink (input valid, input out_channel, input filtered, output ready);
endinterface

>>> rtl/multichannel_iir_order6_filter.sv
// ----------------------------------------------------------------------------
// multichannel_iir_order6_filter
// Sixth-order direct-form-I IIR filter shared over up to CHANNELS channels.
// ----------------------------------------------------------------------------
// Each transfer on samples carries a channel number and a signed 24-bit
// sample; one result per sample leaves on results, in order. The next sample
// is taken only after the last result is loaded into the output register: the
// single coefficient multiplier issues 19 partial products
// (the new sample, six past inputs, and two halves of each of six past Q24.24
// outputs), the history memories give one tap per read, and the
// multiply-accumulate-round pipeline drains before the result is
// registered. A finished result waits in the output register while the next
// sample is taken. A channel at or beyond CHANNELS returns 0 and leaves all
// history untouched. History rows read as zero until their channel is first
// filtered, so no clearing pass follows reset. filter_select (reset 1) must
// be written only while no sample is in flight.
`include "assert_macros.svh"

module multichannel_iir_order6_filter #(
  parameter int CHANNELS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mciir_pkg::FSEL_W-1:0]    cfg_data,
  mciir_in_if.sink                        samples,
  mciir_out_if.source                     results
);
  import mciir_pkg::*;

  localparam int AW    = $clog2(CHANNELS * TAPS);
  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_X0    = 3'd1;
  localparam logic [2:0] ST_P1    = 3'd2;
  localparam logic [2:0] ST_P2    = 3'd3;
  localparam logic [2:0] ST_P3    = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  localparam logic [2:0] TAP_LAST  = 3'(TAPS - 1);
  localparam logic [1:0] DRAIN_END = 2'd3;

  logic [2:0]          state;
  logic [2:0]          state_next;
  logic [2:0]          tap;
  logic [1:0]          drain_cnt;
  logic [FSEL_W-1:0]   filter_select;
  logic [2:0]          cur_ch;
  logic [SAMPLE_W-1:0] cur_x;
  logic [AW-1:0]       base;
  logic [IDX_W-1:0]    row_idx;
  logic                row_ok;
  logic [SAMPLE_W-1:0] px;
  logic [HIST_W-1:0]   py;
  logic                out_valid;
  logic [2:0]          out_ch;
  logic [SAMPLE_W-1:0] out_data;

  logic                accept;
  logic                in_range;
  logic                out_load;
  logic [2:0]          tap_off;
  logic [AW-1:0]       hist_addr;
  logic [K_W-1:0]      coef_k;
  hist_ctl_t           hctl;
  mac_op_t             mop;
  logic [SAMPLE_W-1:0] rd_x;
  logic [HIST_W-1:0]   rd_y;
  logic [HIST_W-1:0]   mac_y;
  logic [SAMPLE_W-1:0] mac_res;

  assign samples.ready = (state == ST_IDLE);
  assign accept        = samples.valid && samples.ready;
  assign in_range      = 32'(samples.channel) < CHANNELS;
  assign out_load      = (state == ST_DONE) && (!out_valid || results.ready);

  // ---- sequencer ----
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept) state_next = in_range ? ST_X0 : ST_DONE;
      ST_X0:    state_next = ST_P1;
      ST_P1:    state_next = ST_P2;
      ST_P2:    state_next = ST_P3;
      ST_P3:    state_next = (tap == TAP_LAST) ? ST_DRAIN : ST_P1;
      ST_DRAIN: if (drain_cnt == DRAIN_END) state_next = ST_DONE;
      ST_DONE:  if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      tap           <= '0;
      drain_cnt     <= '0;
      out_valid     <= 1'b0;
      filter_select <= FSEL_RESET;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        filter_select <= cfg_data;
      end
      case (state)
        ST_X0:    tap <= '0;
        ST_P3:    begin
          if (tap != TAP_LAST) tap <= tap + 3'd1;
          drain_cnt <= '0;
        end
        ST_DRAIN: drain_cnt <= drain_cnt + 2'd1;
        default:  ;
      endcase
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_ch  <= samples.channel;
      cur_x   <= samples.sample;
      row_ok  <= in_range;
      row_idx <= IDX_W'(samples.channel);
      base    <= AW'(samples.channel) * AW'(TAPS);
    end
    // hold the previous tap so it moves one place down the row
    if (state == ST_P1) begin
      px <= rd_x;
      py <= rd_y;
    end
    if (out_load) begin
      out_ch   <= cur_ch;
      out_data <= row_ok ? mac_res : '0;
    end
  end

  // ---- history access ----
  always_comb begin
    case (state)
      ST_P1:   tap_off = tap;
      ST_P3:   tap_off = tap + 3'd1;
      default: tap_off = '0;
    endcase
  end

  assign hist_addr = base + AW'(tap_off);

  always_comb begin
    hctl      = '0;
    hctl.rd   = (state == ST_X0) || ((state == ST_P3) && (tap != TAP_LAST));
    hctl.wr_x = (state == ST_P1);
    hctl.wr_y = ((state == ST_P1) && (tap != '0)) || (out_load && row_ok);
    hctl.mark = out_load && row_ok;
  end

  mciir_hist #(
    .CHANNELS (CHANNELS)
  ) u_hist (
    .clk  (clk),
    .rst  (rst),
    .ctl  (hctl),
    .addr (hist_addr),
    .row  (row_idx),
    .wr_x ((tap == '0) ? cur_x : px),
    .wr_y ((state == ST_DONE) ? mac_y : py),
    .rd_x (rd_x),
    .rd_y (rd_y)
  );

  // ---- multiplier issue ----
  always_comb begin
    case (state)
      ST_P1:   coef_k = K_W'(tap) + K_W'(1);
      ST_P2:   coef_k = K_W'(A_BASE) + K_W'(tap);
      ST_P3:   coef_k = K_W'(A_BASE) + K_W'(tap);
      default: coef_k = '0;
    endcase
  end

  always_comb begin
    mop          = '0;
    mop.launch   = (state == ST_X0) || (state == ST_P1) || (state == ST_P2) ||
                   (state == ST_P3);
    mop.first    = (state == ST_X0);
    mop.shift_up = (state != ST_P3);
    mop.coef     = COEF_TBL[filter_select][coef_k];
    case (state)
      ST_X0:   mop.chunk = {cur_x[SAMPLE_W-1], cur_x};
      ST_P1:   mop.chunk = {rd_x[SAMPLE_W-1], rd_x};
      ST_P2:   mop.chunk = {py[HIST_W-1], py[HIST_W-1:24]};
      ST_P3:   mop.chunk = {1'b0, py[23:0]};
      default: mop.chunk = '0;
    endcase
  end

  mciir_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .op     (mop),
    .y_hist (mac_y),
    .result (mac_res)
  );

  assign results.valid       = out_valid;
  assign results.out_channel = out_ch;
  assign results.filtered    = out_data;

  `CHK_IMPL(a_hist_rw_apart, clk, rst, hctl.rd, !(hctl.wr_x || hctl.wr_y))
  `CHK_IMPL(a_hist_wr_in_range, clk, rst, (hctl.wr_x || hctl.wr_y || hctl.mark), row_ok)
  `CHK_IMPL(a_launch_in_range, clk, rst, mop.launch, row_ok && (tap <= TAP_LAST))
  `CHK_NEXT(a_done_to_idle, clk, rst, out_load, (state == ST_IDLE) && results.valid)

endmodule

>>> rtl/mciir_hist.sv
// ----------------------------------------------------------------------------
// mciir_hist
// Input and output history memories, one row of taps per channel, with a
// per-row valid bit so that rows never written read back as zero.
// ----------------------------------------------------------------------------
module mciir_hist #(
  parameter int  CHANNELS = 8,
  localparam int DEPTH    = CHANNELS * mciir_pkg::TAPS,
  localparam int AW       = $clog2(DEPTH),
  localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  mciir_pkg::hist_ctl_t            ctl,
  input  logic [AW-1:0]                   addr,
  input  logic [IDX_W-1:0]                row,
  input  logic [mciir_pkg::SAMPLE_W-1:0]  wr_x,
  input  logic [mciir_pkg::HIST_W-1:0]    wr_y,
  output logic [mciir_pkg::SAMPLE_W-1:0]  rd_x,
  output logic [mciir_pkg::HIST_W-1:0]    rd_y
);
  import mciir_pkg::*;

  logic [SAMPLE_W-1:0] xmem [DEPTH];
  logic [HIST_W-1:0]   ymem [DEPTH];
  logic [SAMPLE_W-1:0] xq;
  logic [HIST_W-1:0]   yq;
  logic                row_valid [CHANNELS];
  logic                rd_ok;

  always_ff @(posedge clk) begin
    if (ctl.wr_x) begin
      xmem[addr] <= wr_x;
    end
    if (ctl.rd) begin
      xq <= xmem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_y) begin
      ymem[addr] <= wr_y;
    end
    if (ctl.rd) begin
      yq <= ymem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        row_valid[i] <= 1'b0;
      end
      rd_ok <= 1'b0;
    end else begin
      if (ctl.mark) begin
        row_valid[row] <= 1'b1;
      end
      if (ctl.rd) begin
        rd_ok <= row_valid[row];
      end
    end
  end

  // a row not yet marked valid reads back as zero
  assign rd_x = rd_ok ? xq : '0;
  assign rd_y = rd_ok ? yq : '0;

endmodule

>>> rtl/mciir_mac.sv
// ----------------------------------------------------------------------------
// mciir_mac
// Shared coefficient multiplier and accumulator with rounding to the Q24.24
// history word and to the saturated 24-bit result.
// ----------------------------------------------------------------------------
module mciir_mac (
  input  logic                           clk,
  input  logic                           rst,
  input  mciir_pkg::mac_op_t             op,
  output logic [mciir_pkg::HIST_W-1:0]   y_hist,
  output logic [mciir_pkg::SAMPLE_W-1:0] result
);
  import mciir_pkg::*;

  localparam int PH_W   = 57;
  localparam int PL_W   = 58;
  localparam int PROD_W = 89;
  localparam int YS_W   = ACC_W - 56;

  logic signed [31:0]         coef_hi;
  logic signed [32:0]         coef_lo;
  logic signed [CHUNK_W-1:0]  chunk_s;

  logic                       v1, first1, sh1;
  logic signed [PH_W-1:0]     p_hi;
  logic signed [PL_W-1:0]     p_lo;
  logic                       v2, first2, sh2;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    term;
  logic [ACC_W-1:0]           acc_rnd;
  logic [YS_W-1:0]            ys;
  logic [HIST_W-1:0]          y_sat;
  logic [HIST_W:0]            yr;
  logic [SAMPLE_W:0]          rs;
  logic [SAMPLE_W-1:0]        r_sat;
  logic [HIST_W-1:0]          y_q;
  logic [SAMPLE_W-1:0]        r_q;

  assign coef_hi = $signed(op.coef[63:32]);
  assign coef_lo = $signed({1'b0, op.coef[31:0]});
  assign chunk_s = op.chunk;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= op.launch;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    first1 <= op.first;
    sh1    <= op.shift_up;
    p_hi   <= coef_hi * chunk_s;
    p_lo   <= coef_lo * chunk_s;
    first2 <= first1;
    sh2    <= sh1;
    prod   <= (PROD_W'(p_hi) <<< 32) + PROD_W'(p_lo);
  end

  assign term = sh2 ? (ACC_W'(prod) <<< 24) : ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (v2) begin
      acc <= (first2 ? '0 : acc) + term;
    end
  end

  // round half up at bit 56, then clamp to the 48-bit history word
  assign acc_rnd = acc + {{(ACC_W-56){1'b0}}, 1'b1, 55'd0};
  assign ys      = acc_rnd[ACC_W-1:56];

  always_comb begin
    if (ys[YS_W-1] && !(&ys[YS_W-2:HIST_W-1])) begin
      y_sat = {1'b1, {(HIST_W-1){1'b0}}};
    end else if (!ys[YS_W-1] && (|ys[YS_W-2:HIST_W-1])) begin
      y_sat = {1'b0, {(HIST_W-1){1'b1}}};
    end else begin
      y_sat = ys[HIST_W-1:0];
    end
  end

  assign yr = {y_q[HIST_W-1], y_q} + {{(HIST_W-23){1'b0}}, 1'b1, 23'd0};
  assign rs = yr[HIST_W:24];

  always_comb begin
    if (rs[SAMPLE_W] != rs[SAMPLE_W-1]) begin
      r_sat = rs[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      r_sat = rs[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    y_q <= y_sat;
    r_q <= r_sat;
  end

  assign y_hist = y_q;
  assign result = r_q;

endmodule
